FILE: hdl/tdf_pkg.sv
package tdf_pkg;

	localparam int MAX_RESULTS = 19;
	localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ENTRY = 7'b0000010,
		ST_SHIFT = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_TAIL  = 7'b0100000,
		ST_FLUSH = 7'b1000000
	} tdf_state_t;

endpackage

FILE: hdl/tdf_div.sv
module tdf_div
	import tdf_pkg::*;
#(
	parameter int VALUE_BITS = 31,
	parameter int DIV_BITS   = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]   divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [DIV_BITS-1:0]   remainder
);

	localparam int STEP_BITS = $clog2(VALUE_BITS + 1);

	logic [STEP_BITS-1:0]  step_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   dsr_q;

	logic [DIV_BITS:0] trial;
	logic [DIV_BITS:0] diff;
	logic              ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				step_q <= STEP_BITS'(VALUE_BITS);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				done_q <= (step_q == STEP_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step_q != '0) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/trial_division_factorizer_top.sv
// Input of 0 or 1: the start transfer moves the sequencer to ST_ENTRY, which
// raises the registered valid with no_factor set. Otherwise each odd trial
// divisor uses the shared bit-serial divider; ST_SHIFT strips trailing zeros.
// Throughput: one number per run; the next start transfer can land at the edge
// that ends the cycle of the last result. start is taken only while busy is low.
// Reset: arst_n clears the sequencer to idle and valid low; no transfer is invented.
// The receiver cannot stall: each result shows on valid for one cycle.
module trial_division_factorizer_top
	import tdf_pkg::*;
#(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] number,
	output logic                  valid,
	output logic [VALUE_BITS-1:0] factor,
	output logic                  last,
	output logic                  no_factor
);

	localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

	tdf_state_t            state_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [VALUE_BITS-1:0] pend_q;
	logic                  pend_valid_q;
	logic [CNT_BITS-1:0]   count_q;

	logic                  valid_q;
	logic [VALUE_BITS-1:0] factor_q;
	logic                  last_q;
	logic                  no_factor_q;

	logic                  div_go;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DIV_BITS-1:0]   div_rem;

	logic                  past_root;
	logic                  divides;
	logic                  emit;
	logic [VALUE_BITS-1:0] emit_factor;
	logic                  emit_last;
	logic                  emit_nf;

	assign div_go = (state_q == ST_DIV);

	tdf_div #(
		.VALUE_BITS (VALUE_BITS),
		.DIV_BITS   (DIV_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (rem_q),
		.divisor   (div_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// divisor > remaining / divisor ends the trial loop
	assign past_root = VALUE_BITS'(div_q) > div_quo;
	assign divides   = (div_rem == '0);

	always_comb begin
		emit        = 1'b0;
		emit_factor = pend_q;
		emit_last   = 1'b0;
		emit_nf     = 1'b0;
		case (state_q)
			ST_ENTRY: begin
				if (rem_q < VALUE_BITS'(2)) begin
					emit        = 1'b1;
					emit_factor = '0;
					emit_last   = 1'b1;
					emit_nf     = 1'b1;
				end
			end
			ST_WAIT: begin
				emit = div_done && !past_root && divides && pend_valid_q;
			end
			ST_TAIL: begin
				emit = (rem_q > VALUE_BITS'(2)) && pend_valid_q;
			end
			ST_FLUSH: begin
				emit      = 1'b1;
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rem_q        <= '0;
			div_q        <= DIV_BITS'(3);
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= emit;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rem_q        <= number;
						div_q        <= DIV_BITS'(3);
						count_q      <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_ENTRY;
					end
				end
				ST_ENTRY: begin
					if (rem_q < VALUE_BITS'(2)) begin
						state_q <= ST_IDLE;
					end else if (!rem_q[0]) begin
						pend_q       <= VALUE_BITS'(2);
						pend_valid_q <= 1'b1;
						count_q      <= CNT_BITS'(1);
						state_q      <= ST_SHIFT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_SHIFT: begin
					if (!rem_q[0]) begin
						rem_q <= rem_q >> 1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (past_root) begin
							state_q <= ST_TAIL;
						end else if (divides) begin
							pend_q       <= VALUE_BITS'(div_q);
							pend_valid_q <= 1'b1;
							count_q      <= count_q + 1'b1;
							rem_q        <= div_quo;
							if (count_q + 1'b1 == CNT_BITS'(MAX_RESULTS)) begin
								state_q <= ST_FLUSH;
							end else begin
								state_q <= ST_DIV;
							end
						end else begin
							div_q   <= div_q + DIV_BITS'(2);
							state_q <= ST_DIV;
						end
					end
				end
				ST_TAIL: begin
					if (rem_q > VALUE_BITS'(2)) begin
						pend_q       <= rem_q;
						pend_valid_q <= 1'b1;
					end
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			factor_q    <= emit_factor;
			last_q      <= emit_last;
			no_factor_q <= emit_nf;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign valid     = valid_q;
	assign factor    = factor_q;
	assign last      = last_q;
	assign no_factor = no_factor_q;

	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && last)
		else $error("run ended without a last transfer");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("last transfer while still busy");

	a_no_factor: assert property (@(posedge clk) disable iff (!arst_n)
		valid && no_factor |-> last && factor == '0)
		else $error("bad no-factor transfer");

	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> div_q[0])
		else $error("trial divisor is even");

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> pend_valid_q)
		else $error("flush with no pending factor");

endmodule

FILE: dv/tb_trial_division_factorizer_top.sv
module tb_trial_division_factorizer_top
	import tdf_pkg::*;
();

	localparam int VW          = 31;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int SETTLE      = 64;

	typedef struct packed {
		logic [VW-1:0] factor;
		logic          last;
		logic          no_factor;
	} factor_item_t;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	logic [VW-1:0] number = '0;
	logic          busy;
	logic          valid;
	logic [VW-1:0] factor;
	logic          last;
	logic          no_factor;

	factor_item_t expected_factors[$];
	int           numbers_sent    = 0;
	int           factors_checked = 0;
	int           mismatches      = 0;
	int           sender_idle_pct = 0;
	int           cycle_count     = 0;

	trial_division_factorizer_top #(.VALUE_BITS(VW)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.number    (number),
		.valid     (valid),
		.factor    (factor),
		.last      (last),
		.no_factor (no_factor)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d factors still outstanding", $time,
				expected_factors.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ascending prime factors, at most MAX_RESULTS; 2 once, odd primes with multiplicity; 0 and 1 give a no-factor item
	task automatic predict_factors(input logic [VW-1:0] value);
		logic [VW-1:0] rem;
		logic [VW-1:0] trial;
		logic [VW-1:0] found[$];
		factor_item_t  item;
		rem   = value;
		trial = VW'(3);
		if (rem < 2) begin
			item.factor    = '0;
			item.last      = 1'b1;
			item.no_factor = 1'b1;
			expected_factors.push_back(item);
			return;
		end
		if (!rem[0]) begin
			found.push_back(VW'(2));
			while (!rem[0])
				rem = rem >> 1;
		end
		while (found.size() < MAX_RESULTS && trial <= rem / trial) begin
			if (rem % trial == 0) begin
				found.push_back(trial);
				rem = rem / trial;
			end else begin
				trial = trial + VW'(2);
			end
		end
		if (found.size() < MAX_RESULTS && rem > 2)
			found.push_back(rem);
		foreach (found[i]) begin
			item.factor    = found[i];
			item.last      = (i == found.size() - 1);
			item.no_factor = 1'b0;
			expected_factors.push_back(item);
		end
	endtask

	always @(posedge clk) begin : factor_checker
		factor_item_t want;
		if (arst_n && valid) begin
			if (expected_factors.size() == 0) begin
				if (mismatches < 50)
					$display("%0t: unexpected result: expected none, got factor %0d last %0b no_factor %0b",
						$time, factor, last, no_factor);
				mismatches++;
			end else begin
				want = expected_factors.pop_front();
				factors_checked++;
				if (factor !== want.factor || last !== want.last
						|| no_factor !== want.no_factor) begin
					if (mismatches < 50)
						$display("%0t: expected factor %0d last %0b no_factor %0b, got factor %0d last %0b no_factor %0b",
							$time, want.factor, want.last, want.no_factor,
							factor, last, no_factor);
					mismatches++;
				end
			end
		end
	end

	// start stays high after a transfer; the caller either sends again or
	// drains in the same time step
	task automatic send_number(input logic [VW-1:0] value);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(posedge clk);
		end
		start  <= 1'b1;
		number <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_factors(value);
		numbers_sent++;
	endtask

	task automatic wait_for_factors_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_factors.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly products of small odd values, shifted up; cheap to factor
	function automatic logic [VW-1:0] random_number();
		logic [63:0] v;
		logic [63:0] m;
		int          shift;
		if ($urandom_range(9) == 0)
			return VW'($urandom_range(0, 300));
		v = 1;
		repeat ($urandom_range(0, 10)) begin
			m = 64'($urandom_range(1, 48) * 2 + 1);
			if (v * m < (64'd1 << VW))
				v = v * m;
		end
		if ($urandom_range(1)) begin
			m = 64'($urandom_range(0, 127) * 2 + 1);
			if (v * m < (64'd1 << VW))
				v = v * m;
		end
		shift = $urandom_range(0, VW - 1);
		while (shift > 0 && (v << 1) < (64'd1 << VW)) begin
			v = v << 1;
			shift--;
		end
		return v[VW-1:0];
	endfunction

	task automatic test_zero_and_one();
		send_number(VW'(0));
		send_number(VW'(1));
		wait_for_factors_drained();
	endtask

	task automatic test_small_values();
		send_number(VW'(2));
		send_number(VW'(3));
		send_number(VW'(4));
		send_number(VW'(6));
		send_number(VW'(9));
		send_number(VW'(15));
		send_number(VW'(25));
		send_number(VW'(49));
		wait_for_factors_drained();
	endtask

	task automatic test_power_of_two();
		send_number(VW'(1) << (VW - 1));
		wait_for_factors_drained();
	endtask

	// 3^19: a run that reaches MAX_RESULTS factors
	task automatic test_longest_run();
		send_number(VW'(1162261467));
		wait_for_factors_drained();
	endtask

	task automatic test_field_extremes();
		send_number(VW'(2147483646));
		send_number(VW'(1073741825));
		send_number({VW{1'b1}});
		wait_for_factors_drained();
	endtask

	task automatic test_random_numbers(input int count, input int idle_pct);
		sender_idle_pct = idle_pct;
		repeat (count) begin
			send_number(random_number());
			if ($urandom_range(19) == 0)
				wait_for_factors_drained();
		end
		wait_for_factors_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 7;
		test_zero_and_one();
		test_small_values();
		test_power_of_two();
		test_longest_run();
		test_field_extremes();
		test_random_numbers(28, 7);
		test_random_numbers(28, 63);
		test_random_numbers(28, 0);

		$display("%0d numbers factored, %0d factor results compared, %0d mismatches",
			numbers_sent, factors_checked, mismatches);
		$display("covered 0 and 1, powers of two, the 3^19 run, 2^31-1 and random composites");
		if (mismatches == 0 && expected_factors.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tdf_pkg.sv
hdl/tdf_div.sv
hdl/trial_division_factorizer_top.sv
dv/tb_trial_division_factorizer_top.sv
